/* hdl/positional_list_engine_top_defines.svh */
// ---------------------------------------------------------------------------
// positional list engine assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// clocked property, disabled while the active-low reset is low
`define PLE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define PLE_ASSERT(lbl, prop, msg) \
    `PLE_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* hdl/ple_pkg.sv */
// ---------------------------------------------------------------------------
// ple_pkg
// sizes, request codes and cell command types of the positional list engine
// ---------------------------------------------------------------------------
package ple_pkg;

    // list geometry
    localparam int MAX_LEN   = 16;
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 3;
    localparam int FIDX_W    = 5;
    localparam int LCNT_W    = 5;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    // stream word widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_USED_W  = 1 + DATA_W + FIDX_W + LCNT_W + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_READ   = 3'd2,
        REQ_LOCATE = 3'd3,
        REQ_PRED   = 3'd4,
        REQ_SUCC   = 3'd5,
        REQ_CLEAR  = 3'd6,
        REQ_QUERY  = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    // command broadcast to every cell
    typedef struct packed {
        t_cell_op               op;
        t_req                   req;
        logic [CMP_W-1:0]       pos;
        logic [DATA_W-1:0]      value;
        logic [CNT_W-1:0]       count;
    } t_cell_cmd;

    // per-cell answer: first hit along the chain and the data it selects
    typedef struct packed {
        logic                   hit;
        logic [DATA_W-1:0]      data;
    } t_cell_rsp;

endpackage

/* hdl/positional_list_engine_top.sv */
// ---------------------------------------------------------------------------
// positional_list_engine_top
// ordered list of signed words kept in a row of shifting cells
// timing: the request word is captured, the cell row compares and shifts in the
//   execute state, then the result word is registered and shown in the output state
// flow: a new request is taken only when idle or as the result word is taken
// reset: synchronous active low, empties the list and drops any pending word
// ---------------------------------------------------------------------------
module positional_list_engine_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [4:0] position, [36:5] value, upper bits zero
    input  logic [ple_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] req_type
    input  logic [ple_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] status, [32:1] result_value, [37:33] found_index,
    // [42:38] list_count, [43] is_empty, upper bits zero
    output logic [ple_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    localparam int N = ple_pkg::MAX_LEN;

    ple_pkg::t_state                r_state;
    ple_pkg::t_state                n_state;
    ple_pkg::t_req                  r_req;
    logic [ple_pkg::POS_W-1:0]      r_pos;
    logic [ple_pkg::DATA_W-1:0]     r_val;
    logic [ple_pkg::CNT_W-1:0]      r_count;
    logic [ple_pkg::CNT_W-1:0]      n_count;

    logic                           r_out_status;
    logic [ple_pkg::DATA_W-1:0]     r_out_result;
    logic [ple_pkg::CMP_W-1:0]      r_out_found;
    logic [ple_pkg::CNT_W-1:0]      r_out_count;
    logic                           n_out_status;
    logic [ple_pkg::DATA_W-1:0]     n_out_result;
    logic [ple_pkg::CMP_W-1:0]      n_out_found;

    logic                           w_s_acc;
    logic                           w_load;
    ple_pkg::t_cell_cmd             w_cmd;
    logic [ple_pkg::CMP_W-1:0]      w_pos;
    logic [ple_pkg::CMP_W-1:0]      w_cnt;
    logic                           w_ins_ok;
    logic                           w_pos_ok;
    logic                           w_any_hit;
    logic [ple_pkg::DATA_W-1:0]     w_hit_data;
    logic [ple_pkg::CMP_W-1:0]      w_hit_idx;
    logic [ple_pkg::CMP_W-1:0]      w_out_cnt;

    logic [ple_pkg::DATA_W-1:0]     w_data  [N];
    logic [ple_pkg::DATA_W-1:0]     w_left  [N];
    logic [ple_pkg::DATA_W-1:0]     w_right [N];
    ple_pkg::t_cell_rsp             w_rsp   [N];
    logic [N:0]                     w_found;

    // handshakes
    assign s_axis_tready = (r_state == ple_pkg::ST_IDLE) |
                           ((r_state == ple_pkg::ST_OUT) & m_axis_tready);
    assign w_s_acc       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (r_state == ple_pkg::ST_OUT);

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_req <= ple_pkg::t_req'(s_axis_tuser[ple_pkg::REQ_W-1:0]);
            r_pos <= s_axis_tdata[ple_pkg::POS_W-1:0];
            r_val <= s_axis_tdata[ple_pkg::POS_W +: ple_pkg::DATA_W];
        end
    end

    // position checks against the current count
    assign w_pos    = ple_pkg::CMP_W'(r_pos);
    assign w_cnt    = ple_pkg::CMP_W'(r_count);
    assign w_pos_ok = (w_pos != '0) & (w_pos <= w_cnt);
    assign w_ins_ok = (w_cnt < ple_pkg::CMP_W'(N)) & (w_pos != '0) &
                      ((w_pos - ple_pkg::CMP_W'(1)) <= w_cnt);

    // cell command, only the execute cycle may touch the row
    always_comb begin
        w_cmd.op    = ple_pkg::CELL_HOLD;
        w_cmd.req   = r_req;
        w_cmd.pos   = w_pos;
        w_cmd.value = r_val;
        w_cmd.count = r_count;
        if (r_state == ple_pkg::ST_EXEC) begin
            case (r_req)
                ple_pkg::REQ_INSERT: begin
                    if (w_ins_ok) begin
                        w_cmd.op = ple_pkg::CELL_INS;
                    end
                end
                ple_pkg::REQ_DELETE: begin
                    if (w_pos_ok) begin
                        w_cmd.op = ple_pkg::CELL_DEL;
                    end
                end
                default: begin
                    w_cmd.op = ple_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // cell row
    assign w_found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g] = '0;
            end else begin : g_mid_l
                assign w_left[g] = w_data[g-1];
            end
            if (g == N - 1) begin : g_last
                assign w_right[g] = w_data[g];
            end else begin : g_mid_r
                assign w_right[g] = w_data[g+1];
            end

            ple_cell u_cell (
                .i_clk        (i_clk),
                .i_idx        (ple_pkg::IDX_W'(g)),
                .i_cmd        (w_cmd),
                .i_left_data  (w_left[g]),
                .i_right_data (w_right[g]),
                .i_found      (w_found[g]),
                .o_found      (w_found[g+1]),
                .o_data       (w_data[g]),
                .o_rsp        (w_rsp[g])
            );
        end
    endgenerate

    assign w_any_hit = w_found[N];

    // gather the single hit from the row
    always_comb begin
        w_hit_data = '0;
        w_hit_idx  = '0;
        for (int i = 0; i < N; i++) begin
            if (w_rsp[i].hit) begin
                w_hit_data = w_hit_data | w_rsp[i].data;
                w_hit_idx  = w_hit_idx | ple_pkg::CMP_W'(i + 1);
            end
        end
    end

    // request decode and next result
    always_comb begin
        n_count      = r_count;
        n_out_status = 1'b1;
        n_out_result = '0;
        n_out_found  = '0;
        case (r_req)
            ple_pkg::REQ_INSERT: begin
                if (w_ins_ok) begin
                    n_out_status = 1'b0;
                    n_count      = r_count + ple_pkg::CNT_W'(1);
                end
            end
            ple_pkg::REQ_DELETE: begin
                if (w_pos_ok) begin
                    n_out_status = 1'b0;
                    n_out_result = w_hit_data;
                    n_count      = r_count - ple_pkg::CNT_W'(1);
                end
            end
            ple_pkg::REQ_READ, ple_pkg::REQ_PRED, ple_pkg::REQ_SUCC: begin
                if (w_any_hit) begin
                    n_out_status = 1'b0;
                    n_out_result = w_hit_data;
                end
            end
            ple_pkg::REQ_LOCATE: begin
                if (w_any_hit) begin
                    n_out_status = 1'b0;
                    n_out_found  = w_hit_idx;
                end
            end
            ple_pkg::REQ_CLEAR: begin
                if (r_count != '0) begin
                    n_out_status = 1'b0;
                    n_count      = '0;
                end
            end
            default: begin
                n_out_status = 1'b0;
            end
        endcase
        // only the execute cycle may touch the count
        if (r_state != ple_pkg::ST_EXEC) begin
            n_count = r_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        case (r_state)
            ple_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ple_pkg::ST_EXEC;
                end
            end
            ple_pkg::ST_EXEC: begin
                w_load  = 1'b1;
                n_state = ple_pkg::ST_OUT;
            end
            ple_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = s_axis_tvalid ? ple_pkg::ST_EXEC : ple_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ple_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= n_out_status;
            r_out_result <= n_out_result;
            r_out_found  <= n_out_found;
            r_out_count  <= n_count;
        end
    end

    assign w_out_cnt = ple_pkg::CMP_W'(r_out_count);

    assign m_axis_tdata = {
        {(ple_pkg::M_TDATA_W - ple_pkg::M_USED_W){1'b0}},
        (r_out_count == '0),
        w_out_cnt[ple_pkg::LCNT_W-1:0],
        r_out_found[ple_pkg::FIDX_W-1:0],
        r_out_result,
        r_out_status
    };

endmodule

/* hdl/ple_cell.sv */
// ---------------------------------------------------------------------------
// ple_cell
// one list slot: holds an element, matches it, shifts with its neighbors
// ---------------------------------------------------------------------------
module ple_cell (
    input  logic                            i_clk,
    input  logic [ple_pkg::IDX_W-1:0]       i_idx,
    input  ple_pkg::t_cell_cmd              i_cmd,
    input  logic [ple_pkg::DATA_W-1:0]      i_left_data,
    input  logic [ple_pkg::DATA_W-1:0]      i_right_data,
    input  logic                            i_found,
    output logic                            o_found,
    output logic [ple_pkg::DATA_W-1:0]      o_data,
    output ple_pkg::t_cell_rsp              o_rsp
);

    logic [ple_pkg::DATA_W-1:0] r_data;
    logic [ple_pkg::DATA_W-1:0] n_data;
    logic [ple_pkg::CMP_W-1:0]  w_place;
    logic [ple_pkg::CMP_W-1:0]  w_cnt;
    logic                       w_valid;
    logic                       w_eq;
    logic                       w_elig;
    logic [ple_pkg::DATA_W-1:0] w_sel;

    // 1-based place of this slot and occupancy
    assign w_place = ple_pkg::CMP_W'(i_idx) + ple_pkg::CMP_W'(1);
    assign w_cnt   = ple_pkg::CMP_W'(i_cmd.count);
    assign w_valid = (w_place <= w_cnt);
    assign w_eq    = (r_data == i_cmd.value);

    // eligibility and selected data per request kind
    always_comb begin
        w_elig = 1'b0;
        w_sel  = r_data;
        case (i_cmd.req)
            ple_pkg::REQ_READ, ple_pkg::REQ_DELETE: begin
                w_elig = w_valid & (w_place == i_cmd.pos);
            end
            ple_pkg::REQ_LOCATE: begin
                w_elig = w_valid & w_eq;
            end
            ple_pkg::REQ_PRED: begin
                w_elig = w_valid & w_eq & (w_place >= ple_pkg::CMP_W'(2));
                w_sel  = i_left_data;
            end
            ple_pkg::REQ_SUCC: begin
                w_elig = w_eq & (w_place < w_cnt);
                w_sel  = i_right_data;
            end
            default: begin
                w_elig = 1'b0;
            end
        endcase
    end

    // first-match chain
    assign o_found   = i_found | w_elig;
    assign o_rsp.hit = w_elig & ~i_found;
    assign o_rsp.data = w_sel;
    assign o_data    = r_data;

    // insert opens a gap by taking the left word, delete closes it from the right
    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            ple_pkg::CELL_INS: begin
                if (w_place == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (w_place > i_cmd.pos) begin
                    n_data = i_left_data;
                end
            end
            ple_pkg::CELL_DEL: begin
                if (w_place >= i_cmd.pos) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* hdl/ple_checker.sv */
// ---------------------------------------------------------------------------
// ple_checker
// port-level timing checks of the positional list engine
// ---------------------------------------------------------------------------
`include "positional_list_engine_top_defines.svh"

module ple_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [ple_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    logic w_s_acc;
    logic w_m_stall;

    assign w_s_acc   = s_axis_tvalid & s_axis_tready;
    assign w_m_stall = m_axis_tvalid & !m_axis_tready;

    // a stalled result word holds
    `PLE_ASSERT(a_out_hold, w_m_stall |=> $stable(m_axis_tdata), "result word changed while stalled")

    // result word appears once its request has passed the execute state
    `PLE_ASSERT(a_out_latency, w_s_acc |-> ##2 m_axis_tvalid, "result word not valid two cycles after accept")

    // the cycle after an accept is the execute cycle, nothing is shown
    `PLE_ASSERT(a_exec_gap, w_s_acc |=> !m_axis_tvalid, "result word shown during execute cycle")

    // no new request while a result word waits untaken
    `PLE_ASSERT(a_no_overrun, w_m_stall |-> !s_axis_tready, "request taken while result word stalled")

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
);
